### hdl/wse_pkg.sv
// ----------------------------------------------------------------------------
// wse_pkg
// Shared types and constants of the windowed speed estimator.
// ----------------------------------------------------------------------------
package wse_pkg;

  localparam int COUNT_W    = 32;
  localparam int TIME_W     = 32;
  localparam int UM_W       = 20;
  localparam int SPEED_W    = 24;
  localparam int FILL_OUT_W = 5;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = COUNT_W + UM_W;
  localparam int STEP_W     = 5;

  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(UM_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(SPEED_W - 1);

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  localparam logic [TIME_W-1:0] WINDOW_MS_RST    = 32'd30000;
  localparam logic [UM_W-1:0]   UM_PER_COUNT_RST = 20'd11399;

  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_MS    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_UM_PER_COUNT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_CALC,
    ST_FINISH
  } wse_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_TEST,
    MD_DIV
  } md_state_t;

endpackage

### hdl/wse_if.sv
// ----------------------------------------------------------------------------
// wse_in_if / wse_out_if
// Valid/ready channels for samples and speed results.
// ----------------------------------------------------------------------------
interface wse_in_if;
  logic                        valid;
  logic                        ready;
  logic [wse_pkg::COUNT_W-1:0] tach_count;
  logic [wse_pkg::TIME_W-1:0]  time_ms;

  modport source (output valid, output tach_count, output time_ms, input ready);
  modport sink   (input valid, input tach_count, input time_ms, output ready);
endinterface

interface wse_out_if;
  logic                           valid;
  logic                           ready;
  logic [wse_pkg::SPEED_W-1:0]    speed_mm_s;
  logic                           speed_valid;
  logic [wse_pkg::FILL_OUT_W-1:0] window_fill;

  modport source (output valid, output speed_mm_s, output speed_valid,
                  output window_fill, input ready);
  modport sink   (input valid, input speed_mm_s, input speed_valid,
                  input window_fill, output ready);
endinterface

### hdl/wse_muldiv.sv
// ----------------------------------------------------------------------------
// wse_muldiv
// Bit-serial multiply (dcount * um) then restoring divide by dt, saturating.
// ----------------------------------------------------------------------------
module wse_muldiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wse_pkg::COUNT_W-1:0]   dcount,
  input  logic [wse_pkg::TIME_W-1:0]    dt,
  input  logic [wse_pkg::UM_W-1:0]      um,
  output logic                          done,
  output logic [wse_pkg::SPEED_W-1:0]   speed
);
  import wse_pkg::*;

  md_state_t           state_r, state_nxt;
  logic [STEP_W-1:0]   step_r;
  logic                done_r;
  logic [COUNT_W-1:0]  mcand_r;
  logic [TIME_W-1:0]   dt_r;
  logic [PROD_W-1:0]   p_r;
  logic [TIME_W-1:0]   rem_r;
  logic [SPEED_W-1:0]  q_r;

  logic [COUNT_W:0]    sum;
  logic [PROD_W-1:0]   mul_nxt;
  logic                sat;
  logic [TIME_W:0]     rem_sh;
  logic                ge;
  logic [TIME_W-1:0]   rem_nxt;

  // lsb-first shift-add: multiplier bits sit in the low end of p_r
  assign sum     = {1'b0, p_r[PROD_W-1:UM_W]} + {1'b0, mcand_r};
  assign mul_nxt = p_r[0] ? {sum, p_r[UM_W-1:1]} : {1'b0, p_r[PROD_W-1:1]};

  // quotient overflows 24 bits exactly when product >> 24 is not below dt
  assign sat = TIME_W'(p_r[PROD_W-1:SPEED_W]) >= dt_r;

  assign rem_sh  = {rem_r, p_r[SPEED_W-1]};
  assign ge      = rem_sh >= {1'b0, dt_r};
  assign rem_nxt = ge ? TIME_W'(rem_sh - {1'b0, dt_r}) : rem_sh[TIME_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MD_IDLE: if (start) state_nxt = MD_MUL;
      MD_MUL:  if (step_r == MUL_LAST) state_nxt = MD_TEST;
      MD_TEST: state_nxt = sat ? MD_IDLE : MD_DIV;
      MD_DIV:  if (step_r == DIV_LAST) state_nxt = MD_IDLE;
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == MD_TEST && sat) ||
                 (state_r == MD_DIV && step_r == DIV_LAST);
      if (state_r == MD_MUL || state_r == MD_DIV) begin
        step_r <= (state_nxt == state_r) ? step_r + 1'b1 : '0;
      end else begin
        step_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      MD_IDLE: begin
        if (start) begin
          mcand_r <= dcount;
          dt_r    <= dt;
          p_r     <= {{COUNT_W{1'b0}}, um};
        end
      end
      MD_MUL: p_r <= mul_nxt;
      MD_TEST: begin
        rem_r <= TIME_W'(p_r[PROD_W-1:SPEED_W]);
        if (sat) q_r <= SPEED_MAX;
      end
      MD_DIV: begin
        rem_r              <= rem_nxt;
        p_r[SPEED_W-1:0]   <= {p_r[SPEED_W-2:0], ge};
        if (step_r == DIV_LAST) q_r <= {p_r[SPEED_W-2:0], ge};
      end
      default: ;
    endcase
  end

  assign done  = done_r;
  assign speed = q_r;

endmodule

### hdl/windowed_speed_estimator_unit.sv
// ----------------------------------------------------------------------------
// windowed_speed_estimator_unit
// Sliding-window speed from tachometer samples: ring of recent samples,
// time-window trimming, then a bit-serial (dcount * um_per_count) / dt.
// ----------------------------------------------------------------------------
//  channel   direction  handshake       payload
//  in_item   sink       valid/ready     tach_count, time_ms
//  out_item  source     valid/ready     speed_mm_s, speed_valid, window_fill
//  cfg_*     sink       cfg_we only     cfg_addr, cfg_wdata
//
//  One sample at a time: push, then trim (a read and a check per dropped
//  sample), then the serial multiplier/divider (20 multiply steps, one range
//  test, 24 divide steps, one to hand back the quotient; the divide steps are
//  skipped when the quotient saturates, the unit when the time span is zero),
//  then the output register is loaded. A finished result is parked in the
//  output register; the next sample is taken while it waits, and a result
//  still waiting there holds the following one in the finish state.
//  Synchronous active-low reset; ring contents are never cleared, only the
//  indices and fill count.
// ----------------------------------------------------------------------------
module windowed_speed_estimator_unit #(
  parameter int WINDOW_DEPTH = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  wse_in_if.sink                           in_item,
  wse_out_if.source                        out_item,
  input  logic                             cfg_we,
  input  logic [wse_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [wse_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import wse_pkg::*;

  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 2);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_DEPTH);

  wse_state_t state_r, state_nxt;

  logic [TIME_W-1:0]   window_ms_r;
  logic [UM_W-1:0]     um_r;

  logic [COUNT_W-1:0]  cnt_r;
  logic [TIME_W-1:0]   tms_r;
  logic [IDX_W-1:0]    oldest_r;
  logic [IDX_W-1:0]    newest_r;
  logic [FILL_W-1:0]   fill_r;

  logic [COUNT_W+TIME_W-1:0] ring [WINDOW_DEPTH];
  logic [COUNT_W+TIME_W-1:0] rd_r;

  logic [SPEED_W-1:0]  res_speed_r;
  logic                res_valid_r;

  logic                out_valid_r;
  logic [SPEED_W-1:0]  out_speed_r;
  logic                out_svalid_r;
  logic [FILL_OUT_W-1:0] out_fill_r;

  logic                accept;
  logic [IDX_W-1:0]    newest_inc;
  logic [IDX_W-1:0]    oldest_inc;
  logic [TIME_W-1:0]   span;
  logic [COUNT_W-1:0]  dcount;
  logic                drop;
  logic                md_start;
  logic                md_done;
  logic [SPEED_W-1:0]  md_speed;
  logic                out_free;
  logic [FILL_W+FILL_OUT_W-1:0] fill_wide;

  assign accept     = in_item.valid && in_item.ready;
  assign newest_inc = (newest_r == IDX_LAST) ? '0 : newest_r + 1'b1;
  assign oldest_inc = (oldest_r == IDX_LAST) ? '0 : oldest_r + 1'b1;

  // rd_r holds the oldest sample: count in the upper half, time in the lower
  assign span   = tms_r - rd_r[TIME_W-1:0];
  assign dcount = cnt_r - rd_r[COUNT_W+TIME_W-1:TIME_W];
  assign drop   = (fill_r > FILL_W'(1)) && ((span > window_ms_r) || (fill_r > FILL_MAX));

  assign out_free  = !out_valid_r || out_item.ready;
  assign fill_wide = (FILL_W + FILL_OUT_W)'(fill_r);

  always_comb begin
    state_nxt = state_r;
    md_start  = 1'b0;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (drop) begin
          state_nxt = ST_READ;
        end else if (span == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          md_start  = 1'b1;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC:   if (md_done) state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_ms_r <= WINDOW_MS_RST;
      um_r        <= UM_PER_COUNT_RST;
      oldest_r    <= '0;
      newest_r    <= IDX_LAST;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_WINDOW_MS:    window_ms_r <= cfg_wdata[TIME_W-1:0];
          REG_UM_PER_COUNT: um_r        <= cfg_wdata[UM_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        newest_r <= newest_inc;
        fill_r   <= fill_r + 1'b1;
      end
      if (state_r == ST_CHECK && drop) begin
        oldest_r <= oldest_inc;
        fill_r   <= fill_r - 1'b1;
      end
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ring memory: one write port, one registered read port at the oldest slot
  always_ff @(posedge clk) begin
    if (accept) ring[newest_inc] <= {in_item.tach_count, in_item.time_ms};
    rd_r <= ring[oldest_r];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_r <= in_item.tach_count;
      tms_r <= in_item.time_ms;
    end
    if (state_r == ST_CHECK && !drop && span == '0) begin
      res_speed_r <= '0;
      res_valid_r <= 1'b0;
    end
    if (state_r == ST_CALC && md_done) begin
      res_speed_r <= md_speed;
      res_valid_r <= 1'b1;
    end
    if (state_r == ST_FINISH && out_free) begin
      out_speed_r  <= res_speed_r;
      out_svalid_r <= res_valid_r;
      out_fill_r   <= fill_wide[FILL_OUT_W-1:0];
    end
  end

  wse_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (md_start),
    .dcount (dcount),
    .dt     (span),
    .um     (um_r),
    .done   (md_done),
    .speed  (md_speed)
  );

  assign in_item.ready        = (state_r == ST_IDLE);
  assign out_item.valid       = out_valid_r;
  assign out_item.speed_mm_s  = out_speed_r;
  assign out_item.speed_valid = out_svalid_r;
  assign out_item.window_fill = out_fill_r;

  // trimming never leaves more samples than the ring holds, nor an empty window
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC || state_r == ST_FINISH) |->
      (fill_r <= FILL_MAX && fill_r != '0))
    else $error("window fill out of range after trimming");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> state_r == ST_CALC)
    else $error("divider finished outside the calculation phase");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result presented without a finished item");

  a_accept_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> fill_r == $past(fill_r) + FILL_W'(1))
    else $error("fill count not advanced on sample transfer");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for windowed_speed_estimator_unit. A short table of
// directed samples runs first. Random tachometer rides follow under several
// register settings and several idle patterns on both channels. Every result
// transfer is checked field by field against a typed row or an untimed model of the window.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wse_pkg::*;

  localparam int RING_DEPTH   = 20;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TAIL_CYCLES  = 200;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_LEN     = 600;
  localparam int ROW_COUNT    = 25;

  // indexes with no register behind them
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [SPEED_W-1:0]    speed_mm_s;
    logic                  speed_valid;
    logic [FILL_OUT_W-1:0] window_fill;
  } speed_result_t;

  typedef struct packed {
    logic [COUNT_W-1:0] tach;
    logic [TIME_W-1:0]  stamp;
    logic               typed;
    speed_result_t      res;
  } sample_row_t;

  localparam logic          TYPED      = 1'b1;
  localparam logic          PREDICTED  = 1'b0;
  localparam speed_result_t FROM_MODEL = '0;

  // directed samples under the reset register values
  sample_row_t directed_rows [ROW_COUNT] = '{
    // one sample, then an equal timestamp: no span yet
    {32'd0,          32'd0,          TYPED, 24'd0,     1'b0, 5'd1},
    {32'd0,          32'd0,          TYPED, 24'd0,     1'b0, 5'd2},
    // 1000 counts over 1000 ms gives um_per_count mm/s
    {32'd1000,       32'd1000,       TYPED, 24'd11399, 1'b1, 5'd3},
    {32'hFFFF_FFFF,  32'd1001,       TYPED, SPEED_MAX, 1'b1, 5'd4},
    // huge span empties the window down to the new sample
    {32'hFFFF_FFF0,  32'hFFFF_FFFF,  TYPED, 24'd0,     1'b0, 5'd1},
    // time and count both wrap through zero from here on
    {32'hFFFF_FFFA,  32'd9,          PREDICTED, FROM_MODEL},
    {32'd1,   32'd19,  PREDICTED, FROM_MODEL}, {32'd8,   32'd29,  PREDICTED, FROM_MODEL},
    {32'd15,  32'd39,  PREDICTED, FROM_MODEL}, {32'd22,  32'd49,  PREDICTED, FROM_MODEL},
    {32'd29,  32'd59,  PREDICTED, FROM_MODEL}, {32'd36,  32'd69,  PREDICTED, FROM_MODEL},
    {32'd43,  32'd79,  PREDICTED, FROM_MODEL}, {32'd50,  32'd89,  PREDICTED, FROM_MODEL},
    {32'd57,  32'd99,  PREDICTED, FROM_MODEL}, {32'd64,  32'd109, PREDICTED, FROM_MODEL},
    {32'd71,  32'd119, PREDICTED, FROM_MODEL}, {32'd78,  32'd129, PREDICTED, FROM_MODEL},
    {32'd85,  32'd139, PREDICTED, FROM_MODEL}, {32'd92,  32'd149, PREDICTED, FROM_MODEL},
    {32'd99,  32'd159, PREDICTED, FROM_MODEL}, {32'd106, 32'd169, PREDICTED, FROM_MODEL},
    {32'd113, 32'd179, PREDICTED, FROM_MODEL}, {32'd120, 32'd189, PREDICTED, FROM_MODEL},
    // 21st sample in the span: ring depth forces a drop
    {32'd127, 32'd199, PREDICTED, FROM_MODEL}
  };

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  wse_in_if  in_if ();
  wse_out_if out_if ();

  windowed_speed_estimator_unit #(
    .WINDOW_DEPTH(RING_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_if),
    .out_item  (out_if),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // window model
  logic [COUNT_W-1:0] count_hist [RING_DEPTH];
  logic [TIME_W-1:0]  stamp_hist [RING_DEPTH];
  int unsigned        head_slot;
  int unsigned        tail_slot;
  int unsigned        held;
  logic [TIME_W-1:0]  win_ms;
  logic [UM_W-1:0]    um_count;

  speed_result_t pending_speeds [$];
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  int unsigned   results_seen = 0;
  int unsigned   mismatches   = 0;
  int unsigned   cycle_count  = 0;

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  task automatic predict_speed(input logic [COUNT_W-1:0] tach,
                               input logic [TIME_W-1:0] stamp,
                               output speed_result_t r);
    logic [TIME_W-1:0]  span;
    logic [COUNT_W-1:0] dcount;
    logic [PROD_W-1:0]  quot;
    head_slot = (head_slot + 1) % RING_DEPTH;
    count_hist[head_slot] = tach;
    stamp_hist[head_slot] = stamp;
    held++;
    forever begin
      span = stamp_hist[head_slot] - stamp_hist[tail_slot];
      if (held <= 1 || (span <= win_ms && held <= RING_DEPTH)) break;
      tail_slot = (tail_slot + 1) % RING_DEPTH;
      held--;
    end
    dcount = count_hist[head_slot] - count_hist[tail_slot];
    r.speed_mm_s  = '0;
    r.speed_valid = (span != 0);
    r.window_fill = FILL_OUT_W'(held);
    if (span != 0) begin
      quot = (PROD_W'(dcount) * PROD_W'(um_count)) / PROD_W'(span);
      r.speed_mm_s = (quot > PROD_W'(SPEED_MAX)) ? SPEED_MAX : quot[SPEED_W-1:0];
    end
  endtask

  // valid stays high into the next call unless an idle gap is taken
  task automatic offer_sample(input logic [COUNT_W-1:0] tach,
                              input logic [TIME_W-1:0] stamp,
                              input logic typed, input speed_result_t typed_res);
    speed_result_t predicted;
    in_if.valid      <= 1'b1;
    in_if.tach_count <= tach;
    in_if.time_ms    <= stamp;
    do @(posedge clk); while (!in_if.ready);
    predict_speed(tach, stamp, predicted);
    pending_speeds.push_back(typed ? typed_res : predicted);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic ride(input int unsigned n_items, input int unsigned max_dt);
    logic [COUNT_W-1:0] tach;
    logic [TIME_W-1:0]  stamp;
    int unsigned        pick;
    tach  = $urandom;
    stamp = $urandom;
    for (int unsigned k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        // jump anywhere, usually clears the window
        tach  = $urandom;
        stamp = $urandom;
      end else if (pick < 10) begin
        // big count change in little time: saturation or backward motion
        tach  = tach + $urandom;
        stamp = stamp + $urandom_range(3);
      end else if (pick < 18) begin
        tach = tach + $urandom_range(40);
      end else begin
        tach  = tach + $urandom_range(400);
        stamp = stamp + $urandom_range(max_dt);
      end
      offer_sample(tach, stamp, PREDICTED, FROM_MODEL);
    end
  endtask

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] word);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= word;
    @(posedge clk);
    case (idx)
      REG_WINDOW_MS:    win_ms   = word;
      REG_UM_PER_COUNT: um_count = word[UM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] window_word,
                           input logic [CFG_DATA_W-1:0] um_word,
                           input bit poke_spare,
                           input int unsigned s_pct, input int unsigned r_pct,
                           input int unsigned n_items, input int unsigned max_dt);
    while (pending_speeds.size() != 0) @(posedge clk);
    write_reg(REG_WINDOW_MS, window_word);
    write_reg(REG_UM_PER_COUNT, um_word);
    if (poke_spare) begin
      write_reg(REG_SPARE_2, $urandom);
      write_reg(REG_SPARE_3, $urandom);
    end
    cfg_we <= 1'b0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    ride(n_items, max_dt);
    in_if.valid <= 1'b0;
  endtask

  initial begin : stimulus
    in_if.valid      = 1'b0;
    in_if.tach_count = '0;
    in_if.time_ms    = '0;
    head_slot        = RING_DEPTH - 1;
    tail_slot        = 0;
    held             = 0;
    win_ms           = WINDOW_MS_RST;
    um_count         = UM_PER_COUNT_RST;
    send_idle_pct    = 10;
    recv_idle_pct    = 78;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[r])
      offer_sample(directed_rows[r].tach, directed_rows[r].stamp,
                   directed_rows[r].typed, directed_rows[r].res);
    in_if.valid <= 1'b0;
    run_phase(32'd1000, 32'd11399, 1'b0, 10, 78, 250, 120);
    // widest window and wheel constant, upper data bits above the field set
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 10, 78, 250, 50000);
    run_phase(32'd0, 32'd1, 1'b0, 78, 10, 250, 2);
    run_phase(32'd200, 32'd0, 1'b1, 78, 10, 250, 40);
    run_phase(32'd1, $urandom_range(1, 1048575), 1'b0, 0, 0, 250, 2);
    run_phase($urandom_range(1, 5000), $urandom, 1'b0, 0, 0, 200, 600);
    while (pending_speeds.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin : speed_sink
    int unsigned   hold_left;
    bit            hold_done;
    speed_result_t got;
    speed_result_t want;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got = {out_if.speed_mm_s, out_if.speed_valid, out_if.window_fill};
        results_seen++;
        if (pending_speeds.size() == 0) begin
          $display("%0t: transfer with nothing pending: speed %0d valid %0d fill %0d",
                   $time, got.speed_mm_s, got.speed_valid, got.window_fill);
          mismatches++;
        end else begin
          want = pending_speeds.pop_front();
          if (got.speed_mm_s !== want.speed_mm_s) begin
            $display("%0t: speed_mm_s expected %0d got %0d",
                     $time, want.speed_mm_s, got.speed_mm_s);
            mismatches++;
          end
          if (got.speed_valid !== want.speed_valid) begin
            $display("%0t: speed_valid expected %0d got %0d",
                     $time, want.speed_valid, got.speed_valid);
            mismatches++;
          end
          if (got.window_fill !== want.window_fill) begin
            $display("%0t: window_fill expected %0d got %0d",
                     $time, want.window_fill, got.window_fill);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!hold_done && results_seen == HOLD_AT) begin
        // long stall so the sample side backs up
        hold_done    = 1'b1;
        hold_left    = HOLD_LEN;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
